### rtl/rebc_pkg.sv
// ----------------------------------------------------------------------------
// rebc_pkg
// Shared types and codes for the rotary encoder bounded counter.
// ----------------------------------------------------------------------------
package rebc_pkg;

  // operation codes carried by an input word
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_LOAD   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  // configuration register indexes
  localparam logic [2:0] CFG_STEP_SIZE     = 3'd0;
  localparam logic [2:0] CFG_MIN_LIMIT     = 3'd1;
  localparam logic [2:0] CFG_MAX_LIMIT     = 3'd2;
  localparam logic [2:0] CFG_WRAP_MODE     = 3'd3;
  localparam logic [2:0] CFG_BUTTON_ENABLE = 3'd4;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  // input word
  typedef struct packed {
    opcode_t            opcode;
    logic               clk_level;
    logic               dt_level;
    logic               sw_level;
    logic signed [15:0] load_value;
  } item_t;

  // result word
  typedef struct packed {
    logic signed [15:0] count;
    logic               moved_cw;
    logic               moved_ccw;
    logic               pressed;
    logic               released;
  } result_t;

  // configuration set
  typedef struct packed {
    logic        [14:0] step_size;
    logic signed [15:0] min_limit;
    logic signed [15:0] max_limit;
    logic               wrap_mode;
    logic               button_enable;
  } cfg_t;

endpackage

### rtl/rebc_core.sv
// ----------------------------------------------------------------------------
// rebc_core
// Encoder state and the per-word update: edge detect, bounded step, switch
// flags, load and read-and-clear.
// ----------------------------------------------------------------------------
module rebc_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  rebc_pkg::item_t  item,
  input  rebc_pkg::cfg_t   cfg,
  output rebc_pkg::result_t result
);
  import rebc_pkg::*;

  localparam int SumWidth = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;

  // state registers
  logic                   primed,       primed_next;
  logic                   prev_clk,     prev_clk_next;
  logic                   prev_sw,      prev_sw_next;
  logic [COUNT_WIDTH-1:0] counter,      counter_next;
  logic                   cw_flag,      cw_flag_next;
  logic                   ccw_flag,     ccw_flag_next;
  logic                   press_flag,   press_flag_next;
  logic                   release_flag, release_flag_next;

  logic signed [SumWidth-1:0] cnt_x, step_x, min_x, max_x, load_x;
  logic signed [SumWidth-1:0] sum_up, sum_dn, moved, cnt_out_x;
  logic                       rising, sw_change;
  logic                       press_mid, release_mid;

  // widen operands so the sum cannot overflow
  assign cnt_x  = {{(SumWidth-COUNT_WIDTH){counter[COUNT_WIDTH-1]}}, counter};
  assign step_x = {{(SumWidth-15){1'b0}}, cfg.step_size};
  assign min_x  = {{(SumWidth-16){cfg.min_limit[15]}}, cfg.min_limit};
  assign max_x  = {{(SumWidth-16){cfg.max_limit[15]}}, cfg.max_limit};
  assign load_x = {{(SumWidth-16){item.load_value[15]}}, item.load_value};
  assign sum_up = cnt_x + step_x;
  assign sum_dn = cnt_x - step_x;

  // one-sided limit test in the direction of travel
  always_comb begin
    if (!item.dt_level) begin
      if (sum_up > max_x) moved = cfg.wrap_mode ? min_x : max_x;
      else                moved = sum_up;
    end else begin
      if (sum_dn < min_x) moved = cfg.wrap_mode ? max_x : min_x;
      else                moved = sum_dn;
    end
  end

  assign rising    = item.clk_level && !prev_clk;
  assign sw_change = item.sw_level != prev_sw;

  // next state
  always_comb begin
    primed_next   = primed;
    prev_clk_next = prev_clk;
    prev_sw_next  = prev_sw;
    counter_next  = counter;
    cw_flag_next  = cw_flag;
    ccw_flag_next = ccw_flag;
    press_mid     = press_flag;
    release_mid   = release_flag;
    case (item.opcode)
      OP_SAMPLE: begin
        cw_flag_next  = 1'b0;
        ccw_flag_next = 1'b0;
        prev_clk_next = item.clk_level;
        if (!primed) begin
          primed_next  = 1'b1;
          prev_sw_next = item.sw_level;
        end else begin
          if (rising) begin
            counter_next  = moved[COUNT_WIDTH-1:0];
            cw_flag_next  = !item.dt_level;
            ccw_flag_next = item.dt_level;
          end
          if (cfg.button_enable) begin
            prev_sw_next = item.sw_level;
            if (sw_change) begin
              press_mid   = prev_sw;
              release_mid = !prev_sw;
            end
          end
        end
      end
      OP_LOAD: begin
        counter_next = load_x[COUNT_WIDTH-1:0];
      end
      default: begin
      end
    endcase
    press_flag_next   = (item.opcode == OP_READ) ? 1'b0 : press_mid;
    release_flag_next = (item.opcode == OP_READ) ? 1'b0 : release_mid;
  end

  // result word, flags reported before the read clears them
  assign cnt_out_x = {{(SumWidth-COUNT_WIDTH){counter_next[COUNT_WIDTH-1]}}, counter_next};
  always_comb begin
    result.count     = cnt_out_x[15:0];
    result.moved_cw  = cw_flag_next;
    result.moved_ccw = ccw_flag_next;
    result.pressed   = press_mid;
    result.released  = release_mid;
  end

  // state update, one word per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      primed       <= 1'b0;
      prev_clk     <= 1'b0;
      prev_sw      <= 1'b1;
      counter      <= '0;
      cw_flag      <= 1'b0;
      ccw_flag     <= 1'b0;
      press_flag   <= 1'b0;
      release_flag <= 1'b0;
    end else if (advance) begin
      primed       <= primed_next;
      prev_clk     <= prev_clk_next;
      prev_sw      <= prev_sw_next;
      counter      <= counter_next;
      cw_flag      <= cw_flag_next;
      ccw_flag     <= ccw_flag_next;
      press_flag   <= press_flag_next;
      release_flag <= release_flag_next;
    end
  end

  // checks
  a_dir_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cw_flag && ccw_flag))
    else $error("both direction flags set");

  a_sw_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(press_flag && release_flag))
    else $error("press and release flags both set");

  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    advance && item.opcode == OP_READ |=> !press_flag && !release_flag)
    else $error("read did not clear switch flags");

  a_counter_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(counter))
    else $error("counter changed without a word");

  a_unprimed_no_move: assert property (@(posedge clk) disable iff (rst)
    advance && !primed && item.opcode == OP_SAMPLE |=>
      $stable(counter) && !cw_flag && !ccw_flag)
    else $error("priming sample moved the counter");

endmodule

### rtl/rotary_encoder_bounded_counter.sv
// Pipeline: a word accepted into the input register goes through the core into
// the result register, which raises out_valid; throughput is one word per cycle
// while out_stall does not hold the result. The rate is set by the counter
// update, which each word needs before the next one can use the counter.
// Reset (synchronous, active high) empties both pipeline registers and sets
// the encoder state and the configuration registers to their default values.
// ----------------------------------------------------------------------------
// rotary_encoder_bounded_counter
// Rotary encoder reader with a bounded, clamping or wrapping counter, fed
// with sample, read and load words through an input and a result register.
// ----------------------------------------------------------------------------
module rotary_encoder_bounded_counter #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [rebc_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [rebc_pkg::CfgDataWidth-1:0]   cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          opcode,
  input  logic                                clk_level,
  input  logic                                dt_level,
  input  logic                                sw_level,
  input  logic signed [15:0]                  load_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  count,
  output logic                                moved_cw,
  output logic                                moved_ccw,
  output logic                                pressed,
  output logic                                released
);
  import rebc_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_full;
  result_t core_res;
  result_t out_res;
  logic    advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_size     <= '0;
      cfg.min_limit     <= '0;
      cfg.max_limit     <= '0;
      cfg.wrap_mode     <= 1'b0;
      cfg.button_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STEP_SIZE:     cfg.step_size     <= cfg_data[14:0];
        CFG_MIN_LIMIT:     cfg.min_limit     <= cfg_data;
        CFG_MAX_LIMIT:     cfg.max_limit     <= cfg_data;
        CFG_WRAP_MODE:     cfg.wrap_mode     <= cfg_data[0];
        CFG_BUTTON_ENABLE: cfg.button_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // handshake: the input register moves on whenever the result register
  // is empty or being taken
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item.opcode     <= opcode_t'(opcode);
      in_item.clk_level  <= clk_level;
      in_item.dt_level   <= dt_level;
      in_item.sw_level   <= sw_level;
      in_item.load_value <= load_value;
    end
  end

  rebc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .result  (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign count     = out_res.count;
  assign moved_cw  = out_res.moved_cw;
  assign moved_ccw = out_res.moved_ccw;
  assign pressed   = out_res.pressed;
  assign released  = out_res.released;

endmodule
